### sv/key_value_quicksort_defines.svh
// ----------------------------------------------------------------------------
// key_value_quicksort_defines.svh
// Assertion macros shared by the key/value sorter RTL.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_QUICKSORT_DEFINES_SVH
`define KEY_VALUE_QUICKSORT_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset
`define KVQS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("kvqs assertion failed");
// Check that a condition never holds outside reset
`define KVQS_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("kvqs forbidden condition seen");
`else
`define KVQS_ASSERT(lbl, clk, rst, prop)
`define KVQS_NEVER(lbl, clk, rst, cond)
`endif

`endif

### sv/kvqs_pkg.sv
// ----------------------------------------------------------------------------
// kvqs_pkg
// Shared constants and sequencer state type of the key/value sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package kvqs_pkg;

   localparam int KEY_W      = 32;
   localparam int PAYLOAD_W  = 32;
   localparam int PAIR_W     = KEY_W + PAYLOAD_W;
   localparam int CAPACITY_D = 64;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_POP,
      ST_RANGE,
      ST_PIVOT,
      ST_LO_RD,
      ST_LO_CMP,
      ST_HI_RD,
      ST_HI_CMP,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_PUSH_A,
      ST_PUSH_B,
      ST_OUT_RD,
      ST_OUT_CAP,
      ST_OUT_WAIT
   } state_type;

endpackage

`default_nettype wire

### sv/kvqs_ram.sv
// ----------------------------------------------------------------------------
// kvqs_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kvqs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### sv/key_value_quicksort.sv
// ----------------------------------------------------------------------------
// key_value_quicksort
// Batch sorter for key/payload pairs: load, in-place quicksort, stream out.
// ----------------------------------------------------------------------------
// Pairs are loaded one per cycle into a pair RAM of CAPACITY entries; pairs
// past CAPACITY are dropped and flag every result of that batch. The
// transaction with last_item set starts a Hoare quicksort (middle pivot,
// pairs swapped whole, ascending unsigned key) driven by a sequencer around
// the single-read-port pair RAM and a range-stack RAM. Each compare is a read
// state then a compare state, each swap two writes, and each range carries
// overhead states (pop, open, pivot fetch, two pushes) around its partition.
// Results then stream out one transaction at a time: each is read, captured
// and held until taken, and the next is not read before that; the input is
// stalled from the last pair until the final result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_quicksort #(
   parameter int CAPACITY = kvqs_pkg::CAPACITY_D
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic [kvqs_pkg::KEY_W-1:0]     req_key,
   input  wire logic [kvqs_pkg::PAYLOAD_W-1:0] req_payload,
   input  wire logic                         req_last_item,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic [kvqs_pkg::KEY_W-1:0]     rsp_sorted_key,
   output      logic [kvqs_pkg::PAYLOAD_W-1:0] rsp_sorted_payload,
   output      logic                         rsp_final_result,
   output      logic                         rsp_overflowed
);
   import kvqs_pkg::*;

`include "key_value_quicksort_defines.svh"

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int PTR_W = IDX_W + 2;
   localparam int STK_W = 2 * IDX_W;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic                     drop_ff, drop_in;
   logic [CNT_W-1:0]         sp_ff, sp_in;
   logic [IDX_W-1:0]         first_ff, first_in;
   logic [IDX_W-1:0]         last_ff, last_in;
   logic signed [PTR_W-1:0]  low_ff, low_in;
   logic signed [PTR_W-1:0]  high_ff, high_in;
   logic [KEY_W-1:0]         pivot_ff, pivot_in;
   logic [PAIR_W-1:0]        lo_pair_ff, lo_pair_in;
   logic [PAIR_W-1:0]        hi_pair_ff, hi_pair_in;
   logic [IDX_W-1:0]         k_ff, k_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PAIR_W-1:0]        rsp_pair_ff, rsp_pair_in;
   logic                     rsp_final_ff, rsp_final_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   logic                     pr_wr_en;
   logic [IDX_W-1:0]         pr_wr_addr;
   logic [PAIR_W-1:0]        pr_wr_data;
   logic [IDX_W-1:0]         pr_rd_addr;
   logic [PAIR_W-1:0]        pr_rd_data;
   logic                     sk_wr_en;
   logic [IDX_W-1:0]         sk_wr_addr;
   logic [STK_W-1:0]         sk_wr_data;
   logic [IDX_W-1:0]         sk_rd_addr;
   logic [STK_W-1:0]         sk_rd_data;

   logic                     req_take;
   logic                     store_room;
   logic [CNT_W-1:0]         fill_next;
   logic [IDX_W-1:0]         top_idx;
   logic [IDX_W:0]           mid_sum;
   logic [IDX_W-1:0]         stk_first;
   logic [IDX_W-1:0]         stk_last;
   logic [KEY_W-1:0]         rd_key;
   logic signed [PTR_W-1:0]  first_s;
   logic signed [PTR_W-1:0]  last_s;
   logic                     lo_adv;
   logic                     hi_adv;

   kvqs_ram #(.WIDTH(PAIR_W), .DEPTH(CAPACITY)) u_pair_ram (
      .clock   (clock),
      .wr_en   (pr_wr_en),
      .wr_addr (pr_wr_addr),
      .wr_data (pr_wr_data),
      .rd_addr (pr_rd_addr),
      .rd_data (pr_rd_data)
   );

   kvqs_ram #(.WIDTH(STK_W), .DEPTH(CAPACITY)) u_stack_ram (
      .clock   (clock),
      .wr_en   (sk_wr_en),
      .wr_addr (sk_wr_addr),
      .wr_data (sk_wr_data),
      .rd_addr (sk_rd_addr),
      .rd_data (sk_rd_data)
   );

   // Decode common terms
   assign req_take   = req_valid && !req_stall;
   assign store_room = fill_ff < CNT_W'(CAPACITY);
   assign fill_next  = store_room ? fill_ff + CNT_W'(1) : fill_ff;
   assign top_idx    = IDX_W'(fill_ff - CNT_W'(1));
   assign mid_sum    = {1'b0, stk_first} + {1'b0, stk_last};
   assign stk_first  = sk_rd_data[STK_W-1:IDX_W];
   assign stk_last   = sk_rd_data[IDX_W-1:0];
   assign rd_key     = pr_rd_data[PAIR_W-1:PAYLOAD_W];
   assign first_s    = $signed({2'b00, first_ff});
   assign last_s     = $signed({2'b00, last_ff});
   assign lo_adv     = (low_ff < last_s) && (rd_key < pivot_ff);
   assign hi_adv     = (high_ff > first_s) && (rd_key > pivot_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take && req_last_item) begin
               state_in = (fill_next >= CNT_W'(2)) ? ST_POP : ST_OUT_RD;
            end
         end
         ST_POP:      state_in = (sp_ff == '0) ? ST_OUT_RD : ST_RANGE;
         ST_RANGE:    state_in = (stk_last < stk_first) ? ST_POP : ST_PIVOT;
         ST_PIVOT:    state_in = ST_LO_RD;
         ST_LO_RD:    state_in = ST_LO_CMP;
         ST_LO_CMP:   state_in = lo_adv ? ST_LO_RD : ST_HI_RD;
         ST_HI_RD:    state_in = ST_HI_CMP;
         ST_HI_CMP: begin
            if (hi_adv) begin
               state_in = ST_HI_RD;
            end else begin
               state_in = (low_ff <= high_ff) ? ST_SWAP_A : ST_PUSH_A;
            end
         end
         ST_SWAP_A:   state_in = ST_SWAP_B;
         ST_SWAP_B:   state_in = (low_ff + PTR_W'(1) <= high_ff - PTR_W'(1)) ?
                                 ST_LO_RD : ST_PUSH_A;
         ST_PUSH_A:   state_in = ST_PUSH_B;
         ST_PUSH_B:   state_in = ST_POP;
         ST_OUT_RD:   state_in = ST_OUT_CAP;
         ST_OUT_CAP:  state_in = ST_OUT_WAIT;
         ST_OUT_WAIT: begin
            if (!rsp_stall) begin
               state_in = (k_ff == top_idx) ? ST_LOAD : ST_OUT_RD;
            end
         end
         default:     state_in = ST_LOAD;
      endcase
   end

   // Datapath, memory ports and handshake outputs
   always_comb begin
      fill_in      = fill_ff;
      drop_in      = drop_ff;
      sp_in        = sp_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      pivot_in     = pivot_ff;
      lo_pair_in   = lo_pair_ff;
      hi_pair_in   = hi_pair_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pair_in  = rsp_pair_ff;
      rsp_final_in = rsp_final_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      pr_wr_en     = 1'b0;
      pr_wr_addr   = low_ff[IDX_W-1:0];
      pr_wr_data   = hi_pair_ff;
      pr_rd_addr   = low_ff[IDX_W-1:0];
      sk_wr_en     = 1'b0;
      sk_wr_addr   = sp_ff[IDX_W-1:0];
      sk_wr_data   = {low_ff[IDX_W-1:0], last_ff};
      sk_rd_addr   = IDX_W'(sp_ff - CNT_W'(1));
      req_stall    = (state_ff != ST_LOAD);

      unique case (state_ff)
         ST_LOAD: begin
            // Store the pair, or drop it when full; on last, launch the sort (or go straight to output under two pairs)
            if (req_take) begin
               pr_wr_en   = store_room;
               pr_wr_addr = fill_ff[IDX_W-1:0];
               pr_wr_data = {req_key, req_payload};
               fill_in    = fill_next;
               drop_in    = drop_ff | !store_room;
               if (req_last_item) begin
                  k_in = '0;
                  if (fill_next >= CNT_W'(2)) begin
                     sk_wr_en   = 1'b1;
                     sk_wr_addr = '0;
                     sk_wr_data = {IDX_W'(0), IDX_W'(fill_next - CNT_W'(1))};
                     sp_in      = CNT_W'(1);
                  end
               end
            end
         end
         ST_POP: begin
            // Pop the next pending range; start the output when none is left
            if (sp_ff != '0) begin
               sp_in = sp_ff - CNT_W'(1);
            end
         end
         ST_RANGE: begin
            // Open the range and fetch its middle key
            first_in   = stk_first;
            last_in    = stk_last;
            low_in     = $signed({2'b00, stk_first});
            high_in    = $signed({2'b00, stk_last});
            pr_rd_addr = mid_sum[IDX_W:1];
         end
         ST_PIVOT: begin
            pivot_in = rd_key;
         end
         ST_LO_RD: begin
            pr_rd_addr = low_ff[IDX_W-1:0];
         end
         ST_LO_CMP: begin
            // Advance the low pointer past smaller keys
            if (lo_adv) begin
               low_in = low_ff + PTR_W'(1);
            end else begin
               lo_pair_in = pr_rd_data;
            end
         end
         ST_HI_RD: begin
            pr_rd_addr = high_ff[IDX_W-1:0];
         end
         ST_HI_CMP: begin
            // Retreat the high pointer past larger keys
            if (hi_adv) begin
               high_in = high_ff - PTR_W'(1);
            end else begin
               hi_pair_in = pr_rd_data;
            end
         end
         ST_SWAP_A: begin
            pr_wr_en   = 1'b1;
            pr_wr_addr = low_ff[IDX_W-1:0];
            pr_wr_data = hi_pair_ff;
         end
         ST_SWAP_B: begin
            pr_wr_en   = 1'b1;
            pr_wr_addr = high_ff[IDX_W-1:0];
            pr_wr_data = lo_pair_ff;
            low_in     = low_ff + PTR_W'(1);
            high_in    = high_ff - PTR_W'(1);
         end
         ST_PUSH_A: begin
            // Push the upper part first
            if (low_ff < last_s) begin
               sk_wr_en   = 1'b1;
               sk_wr_data = {low_ff[IDX_W-1:0], last_ff};
               sp_in      = sp_ff + CNT_W'(1);
            end
         end
         ST_PUSH_B: begin
            if (first_s < high_ff) begin
               sk_wr_en   = 1'b1;
               sk_wr_data = {first_ff, high_ff[IDX_W-1:0]};
               sp_in      = sp_ff + CNT_W'(1);
            end
         end
         ST_OUT_RD: begin
            pr_rd_addr = k_ff;
         end
         ST_OUT_CAP: begin
            rsp_valid_in = 1'b1;
            rsp_pair_in  = pr_rd_data;
            rsp_final_in = (k_ff == top_idx);
            rsp_ovf_in   = drop_ff;
         end
         ST_OUT_WAIT: begin
            // Hand off the result; close the batch after the final one
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (k_ff == top_idx) begin
                  fill_in = '0;
                  drop_in = 1'b0;
               end else begin
                  k_in = k_ff + IDX_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         fill_ff      <= '0;
         drop_ff      <= 1'b0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         drop_ff      <= drop_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      last_ff      <= last_in;
      low_ff       <= low_in;
      high_ff      <= high_in;
      pivot_ff     <= pivot_in;
      lo_pair_ff   <= lo_pair_in;
      hi_pair_ff   <= hi_pair_in;
      k_ff         <= k_in;
      rsp_pair_ff  <= rsp_pair_in;
      rsp_final_ff <= rsp_final_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sorted_key     = rsp_pair_ff[PAIR_W-1:PAYLOAD_W];
   assign rsp_sorted_payload = rsp_pair_ff[PAYLOAD_W-1:0];
   assign rsp_final_result   = rsp_final_ff;
   assign rsp_overflowed     = rsp_ovf_ff;

   `KVQS_NEVER(a_fill_range, clock, reset, fill_ff > CNT_W'(CAPACITY))
   `KVQS_NEVER(a_stack_range, clock, reset, sp_ff > CNT_W'(CAPACITY))
   `KVQS_ASSERT(a_valid_state, clock, reset, rsp_valid_ff |-> state_ff == ST_OUT_WAIT)
   `KVQS_ASSERT(a_low_bound, clock, reset, state_ff == ST_LO_RD |-> low_ff <= last_s)
   `KVQS_ASSERT(a_load_empty, clock, reset, $fell(rsp_valid_ff) && state_ff == ST_LOAD |-> fill_ff == '0)

endmodule

`default_nettype wire

### tb/sv/key_value_quicksort_test.sv
// ----------------------------------------------------------------------------
// key_value_quicksort_test
// Self-checking bench for the key/payload batch sorter. Batches of random size
// (with a few directed ones: single pair, duplicates, extreme keys, overflow)
// are loaded with bursty valid. The receiver stalls on its own pattern. A
// scoreboard sorts each batch with the same middle-pivot partition and checks
// every result transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_quicksort_test;

   import kvqs_pkg::*;

   localparam int CAP         = CAPACITY_D;
   localparam int IDLE_LIMIT  = 20000;

   // Predicts sorted batches and checks result transactions against them
   class sort_scoreboard;
      logic [KEY_W-1:0]     batch_key[CAP];
      logic [PAYLOAD_W-1:0] batch_payload[CAP];
      int                   fill;
      bit                   dropped;
      logic [KEY_W-1:0]     want_key[$];
      logic [PAYLOAD_W-1:0] want_payload[$];
      bit                   want_final[$];
      bit                   want_ovf[$];
      int                   errors;
      int                   checked;
      int                   batches;
      int                   overflow_batches;

      function void swap_pair(int a, int b);
         logic [KEY_W-1:0]     tk;
         logic [PAYLOAD_W-1:0] tp;
         tk = batch_key[a];
         tp = batch_payload[a];
         batch_key[a] = batch_key[b];
         batch_payload[a] = batch_payload[b];
         batch_key[b] = tk;
         batch_payload[b] = tp;
      endfunction

      // Hoare partition with an explicit stack of ranges
      function void sort_pairs(int count);
         int               lo_q[$];
         int               hi_q[$];
         int               first;
         int               last;
         int               low;
         int               high;
         logic [KEY_W-1:0] pivot;
         if (count < 2) return;
         lo_q.push_back(0);
         hi_q.push_back(count - 1);
         while (lo_q.size() > 0) begin
            first = lo_q.pop_back();
            last  = hi_q.pop_back();
            if (last < first) continue;
            low   = first;
            high  = last;
            pivot = batch_key[(first + last) / 2];
            do begin
               while (low < last && batch_key[low] < pivot) low++;
               while (high > first && batch_key[high] > pivot) high--;
               if (low <= high) begin
                  swap_pair(low, high);
                  low++;
                  high--;
               end
            end while (low <= high);
            if (low < last) begin
               lo_q.push_back(low);
               hi_q.push_back(last);
            end
            if (first < high) begin
               lo_q.push_back(first);
               hi_q.push_back(high);
            end
         end
      endfunction

      function void note_pair(logic [KEY_W-1:0] k, logic [PAYLOAD_W-1:0] p, bit last_one);
         if (fill < CAP) begin
            batch_key[fill] = k;
            batch_payload[fill] = p;
            fill++;
         end else begin
            dropped = 1;
         end
         if (!last_one) return;
         sort_pairs(fill);
         for (int i = 0; i < fill; i++) begin
            want_key.push_back(batch_key[i]);
            want_payload.push_back(batch_payload[i]);
            want_final.push_back(i == fill - 1);
            want_ovf.push_back(dropped);
         end
         batches++;
         if (dropped) overflow_batches++;
         fill = 0;
         dropped = 0;
      endfunction

      function void check_result(logic [KEY_W-1:0] k, logic [PAYLOAD_W-1:0] p, bit fin,
                                 bit ovf);
         if (want_key.size() == 0) begin
            $error("unexpected result transaction key=%h", k);
            errors++;
            return;
         end
         checked++;
         if (k !== want_key[0]) begin
            $error("sorted_key: expected %h, actual %h", want_key[0], k);
            errors++;
         end
         if (p !== want_payload[0]) begin
            $error("sorted_payload: expected %h, actual %h", want_payload[0], p);
            errors++;
         end
         if (fin !== want_final[0]) begin
            $error("final_result: expected %0b, actual %0b", want_final[0], fin);
            errors++;
         end
         if (ovf !== want_ovf[0]) begin
            $error("overflowed: expected %0b, actual %0b", want_ovf[0], ovf);
            errors++;
         end
         void'(want_key.pop_front());
         void'(want_payload.pop_front());
         void'(want_final.pop_front());
         void'(want_ovf.pop_front());
      endfunction

      function int pending();
         return want_key.size();
      endfunction
   endclass

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_stall;
   logic [KEY_W-1:0]     req_key = '0;
   logic [PAYLOAD_W-1:0] req_payload = '0;
   logic                 req_last_item = 0;
   logic                 rsp_valid;
   logic                 rsp_stall = 0;
   logic [KEY_W-1:0]     rsp_sorted_key;
   logic [PAYLOAD_W-1:0] rsp_sorted_payload;
   logic                 rsp_final_result;
   logic                 rsp_overflowed;

   sort_scoreboard       board;
   int                   idle_cycles = 0;
   int                   pairs_sent;
   bit                   stim_done;
   int                   stall_mode = 0;

   key_value_quicksort u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_key            (req_key),
      .req_payload        (req_payload),
      .req_last_item      (req_last_item),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sorted_key     (rsp_sorted_key),
      .rsp_sorted_payload (rsp_sorted_payload),
      .rsp_final_result   (rsp_final_result),
      .rsp_overflowed     (rsp_overflowed)
   );

   always #5 clock = ~clock;

   // Check results and count idle cycles for the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_sorted_key, rsp_sorted_payload, rsp_final_result,
                               rsp_overflowed);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver stall pattern: phases of none, light, heavy and long stalls
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 15) != 0);
      endcase
   end

   // Watchdog
   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Send one pair; valid stays high into the next call when no gap follows
   task automatic send_pair(logic [KEY_W-1:0] k, logic [PAYLOAD_W-1:0] p, bit last_one);
      req_valid     <= 1'b1;
      req_key       <= k;
      req_payload   <= p;
      req_last_item <= last_one;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_pair(k, p, last_one);
      pairs_sent++;
   endtask

   task automatic drop_valid(int gap);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   // Random key with frequent duplicates and extremes
   function automatic logic [KEY_W-1:0] pick_key(int style);
      case (style)
         0: return $urandom();
         1: return $urandom_range(0, 3);
         2: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
         default: return {3'($urandom_range(0, 7)), 29'h0} | 32'($urandom_range(0, 1));
      endcase
   endfunction

   // Send a batch of n pairs; bursty gaps between pairs
   task automatic send_batch(int n, int style);
      int burst;
      burst = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         send_pair(pick_key(style), $urandom(), i == n - 1);
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0) drop_valid($urandom_range(1, 6));
         end
      end
      if ($urandom_range(0, 1) == 0) drop_valid($urandom_range(1, 4));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      board = new();
      pairs_sent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single pair, extreme keys and payloads, duplicates
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
      send_pair(32'hFFFF_FFFF, 32'h0, 0);
      send_pair(32'h0, 32'hFFFF_FFFF, 0);
      send_pair(32'h8000_0000, 32'h1, 0);
      send_pair(32'h7FFF_FFFF, 32'h2, 0);
      send_pair(32'h0, 32'h3, 1);
      for (int i = 0; i < 8; i++) send_pair(32'h5, i, i == 7);
      send_pair(32'h10, 32'hA, 0);
      send_pair(32'h1, 32'hB, 1);
      for (int i = 0; i < 5; i++) send_pair(5 - i, 32'hAAAA_5555 ^ i, i == 4);
      // Pause until every result is out
      wait_drained();

      // Overflow: full store plus dropped pairs, last one dropped too
      send_batch(CAP + 3, 0);
      wait_drained();
      send_batch(CAP, 1);
      send_batch(CAP + 1, 2);

      // Random batches, mostly small sizes
      while (pairs_sent < 230) begin
         if (pairs_sent < 230 - CAP - 2 && $urandom_range(0, 9) == 0)
            send_batch($urandom_range(CAP - 2, CAP + 2), $urandom_range(0, 3));
         else
            send_batch($urandom_range(1, 12), $urandom_range(0, 3));
      end
      wait_drained();
      repeat (50) @(posedge clock);

      $display("sent %0d pairs in %0d batches (%0d overflowed), checked %0d results",
               pairs_sent, board.batches, board.overflow_batches, board.checked);
      if (board.errors == 0 && board.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
